// ===== hdl/tfcm_pkg.sv =====
// Shared types and constants for the transfer function color map.
package tfcm_pkg;

  // Q1.16 position of a control point or table entry
  localparam int unsigned PosW  = 17;
  localparam int unsigned NumW  = 33;
  localparam int unsigned QuoW  = 17;
  localparam logic [PosW-1:0] OneQ16 = 17'h10000;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CHK,
    ST_INS_RD,
    ST_INS_CHK,
    ST_RB_FIRST,
    ST_RB_LAST,
    ST_RB_NEXT,
    ST_RB_SEG,
    ST_RB_ENTRY,
    ST_RB_DIV,
    ST_RB_LERP,
    ST_RB_WRITE,
    ST_MAP_IDX,
    ST_MAP_RD,
    ST_MAP_LERP
  } state_e;

endpackage

// ===== hdl/transfer_function_color_map.sv =====
// Top level of the piecewise-linear transfer function color map.
//
// Usage: drive op_i, scalar_i and the color inputs with start_i high; the
// item is taken at an edge where busy_o is low. Exactly one result follows,
// shown for one cycle with valid_o high; the receiver cannot stall it.
// An add (op 0) scans the point memory one entry at a time and, when the
// position is new, shifts larger points up one entry at a time.
// A map (op 1) on a clean table runs an index multiply, a two-port
// table read and the lane interpolation.
// A map on a stale table first rebuilds all LUT_ENTRIES entries; an entry
// between two points waits on the bit-serial fraction divider, and each
// segment change loads the next point. A map with no points reports empty.
// Reset clears the point count and marks the table stale; no clearing pass
// is run, since no entry is read before it is written.
module transfer_function_color_map #(
  parameter int unsigned MAX_POINTS   = 16,
  parameter int unsigned LUT_ENTRIES  = 1024,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        op_i,
  input  logic [17:0] scalar_i,
  input  logic [15:0] red_i,
  input  logic [15:0] green_i,
  input  logic [15:0] blue_i,
  input  logic [15:0] alpha_i,
  output logic        valid_o,
  output logic [15:0] out_red_o,
  output logic [15:0] out_green_o,
  output logic [15:0] out_blue_o,
  output logic [15:0] out_alpha_o,
  output logic [1:0]  status_o
);

  localparam int unsigned CB   = CHANNEL_BITS;
  localparam int unsigned PW   = tfcm_pkg::PosW;
  localparam int unsigned ColW = 4 * CB;
  localparam int unsigned PtW  = PW + ColW;
  localparam int unsigned AW   = $clog2(MAX_POINTS);
  localparam int unsigned IW   = $clog2(LUT_ENTRIES);
  localparam int unsigned FW   = PW + IW;
  localparam int unsigned Q0   = 65536 / (LUT_ENTRIES - 1);
  localparam int unsigned R0   = 65536 % (LUT_ENTRIES - 1);

  tfcm_pkg::state_e state_q, state_d;

  // control registers
  logic [AW:0]   count_q;
  logic          stale_q;
  logic          valid_q;

  // item registers
  logic [PW-1:0]   key_q;
  logic [ColW-1:0] col_q;
  logic [AW:0]     scan_q, pos_q, seg_q;

  // rebuild registers
  logic [PtW-1:0]  first_q, last_q, a_q, b_q;
  logic [IW-1:0]   ent_q;
  logic [PW-1:0]   epos_q;
  logic [IW:0]     erem_q, erem_sum;
  logic [ColW-1:0] wcol_q;
  logic [PW-1:0]   t_q;

  // map registers
  logic [IW-1:0]   idx_q;

  // output registers
  logic [15:0]     ored_q, ogreen_q, oblue_q, oalpha_q;
  tfcm_pkg::status_e ostat_q;

  // point memory
  logic [PtW-1:0]  pt_mem [MAX_POINTS];
  logic [PtW-1:0]  pt_rd_q;
  logic [AW-1:0]   pt_raddr, pt_waddr;
  logic [PtW-1:0]  pt_wdata;
  logic            pt_we;

  // table memory
  logic [ColW-1:0] lut_mem [LUT_ENTRIES];
  logic [ColW-1:0] lut_a_q, lut_b_q;

  // divider
  logic            div_start, div_done;
  logic [tfcm_pkg::QuoW-1:0] div_quot;
  logic [PW-1:0]   seg_span, seg_off;

  logic            accept;
  logic [PW-1:0]   key_in;
  logic [PW-1:0]   rd_pos;
  logic            full, in_first, in_last, advance, match, shift_up;
  logic [FW-1:0]   fmul;
  logic            last_ent;

  assign accept = start_i && (state_q == tfcm_pkg::ST_IDLE);
  assign busy_o = (state_q != tfcm_pkg::ST_IDLE);

  // scalar clamp to 0..1.0
  always_comb begin
    if (scalar_i[17])                  key_in = '0;
    else if (scalar_i[16:0] > tfcm_pkg::OneQ16) key_in = tfcm_pkg::OneQ16;
    else                               key_in = scalar_i[16:0];
  end

  // decisions
  assign rd_pos   = pt_rd_q[PtW-1 -: PW];
  assign full     = (count_q == (AW+1)'(MAX_POINTS));
  assign match    = (rd_pos == key_q);
  assign shift_up = (rd_pos > key_q);
  assign in_first = (epos_q <= first_q[PtW-1 -: PW]);
  assign in_last  = (epos_q >= last_q[PtW-1 -: PW]);
  assign advance  = (epos_q > b_q[PtW-1 -: PW]);
  assign seg_off  = epos_q - a_q[PtW-1 -: PW];
  assign seg_span = b_q[PtW-1 -: PW] - a_q[PtW-1 -: PW];
  assign last_ent = (ent_q == IW'(LUT_ENTRIES - 1));
  assign erem_sum = erem_q + (IW+1)'(R0);
  assign fmul     = FW'(key_q) * FW'(LUT_ENTRIES - 1);

  // interpolation lanes, shared by rebuild and map
  logic [CB-1:0] lane_res [4];
  for (genvar k = 0; k < 4; k++) begin : g_lane
    logic [CB-1:0] la, lb, dif, sh;
    logic [CB+16:0] prod;
    logic ge;
    assign la   = (state_q == tfcm_pkg::ST_MAP_LERP) ? lut_a_q[k*CB +: CB] : a_q[k*CB +: CB];
    assign lb   = (state_q == tfcm_pkg::ST_MAP_LERP) ? lut_b_q[k*CB +: CB] : b_q[k*CB +: CB];
    assign ge   = (lb >= la);
    assign dif  = ge ? lb - la : la - lb;
    assign prod = (CB+17)'(dif) * (CB+17)'(t_q);
    assign sh   = prod[CB+15:16];
    assign lane_res[k] = ge ? la + sh : la - sh;
  end

  tfcm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({seg_off, 16'h0000}),
    .den_i   (seg_span),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfcm_pkg::ST_IDLE: begin
        if (accept) begin
          if (!op_i)                state_d = tfcm_pkg::ST_ADD_RD;
          else if (count_q == '0)   state_d = tfcm_pkg::ST_IDLE;
          else if (stale_q)         state_d = tfcm_pkg::ST_RB_FIRST;
          else                      state_d = tfcm_pkg::ST_MAP_IDX;
        end
      end
      tfcm_pkg::ST_ADD_RD: begin
        if (scan_q != count_q)  state_d = tfcm_pkg::ST_ADD_CHK;
        else if (full)          state_d = tfcm_pkg::ST_IDLE;
        else                    state_d = tfcm_pkg::ST_INS_RD;
      end
      tfcm_pkg::ST_ADD_CHK: state_d = match ? tfcm_pkg::ST_IDLE : tfcm_pkg::ST_ADD_RD;
      tfcm_pkg::ST_INS_RD:  state_d = (pos_q == '0) ? tfcm_pkg::ST_IDLE : tfcm_pkg::ST_INS_CHK;
      tfcm_pkg::ST_INS_CHK: state_d = shift_up ? tfcm_pkg::ST_INS_RD : tfcm_pkg::ST_IDLE;
      tfcm_pkg::ST_RB_FIRST: state_d = tfcm_pkg::ST_RB_LAST;
      tfcm_pkg::ST_RB_LAST:  state_d = tfcm_pkg::ST_RB_NEXT;
      tfcm_pkg::ST_RB_NEXT:  state_d = tfcm_pkg::ST_RB_SEG;
      tfcm_pkg::ST_RB_SEG:   state_d = tfcm_pkg::ST_RB_ENTRY;
      tfcm_pkg::ST_RB_ENTRY: begin
        if (in_first || in_last) state_d = tfcm_pkg::ST_RB_WRITE;
        else if (advance)        state_d = tfcm_pkg::ST_RB_SEG;
        else                     state_d = tfcm_pkg::ST_RB_DIV;
      end
      tfcm_pkg::ST_RB_DIV:   if (div_done) state_d = tfcm_pkg::ST_RB_LERP;
      tfcm_pkg::ST_RB_LERP:  state_d = tfcm_pkg::ST_RB_WRITE;
      tfcm_pkg::ST_RB_WRITE: state_d = last_ent ? tfcm_pkg::ST_MAP_IDX : tfcm_pkg::ST_RB_ENTRY;
      tfcm_pkg::ST_MAP_IDX:  state_d = tfcm_pkg::ST_MAP_RD;
      tfcm_pkg::ST_MAP_RD:   state_d = tfcm_pkg::ST_MAP_LERP;
      tfcm_pkg::ST_MAP_LERP: state_d = tfcm_pkg::ST_IDLE;
      default:               state_d = tfcm_pkg::ST_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    pt_raddr  = '0;
    pt_waddr  = pos_q[AW-1:0];
    pt_wdata  = {key_q, col_q};
    pt_we     = 1'b0;
    div_start = 1'b0;
    case (state_q)
      tfcm_pkg::ST_ADD_RD:  pt_raddr = scan_q[AW-1:0];
      tfcm_pkg::ST_ADD_CHK: begin
        pt_waddr = scan_q[AW-1:0];
        pt_we    = match;
      end
      tfcm_pkg::ST_INS_RD: begin
        pt_raddr = AW'(pos_q - 1'b1);
        pt_we    = (pos_q == '0);
      end
      tfcm_pkg::ST_INS_CHK: begin
        pt_we = 1'b1;
        if (shift_up) pt_wdata = pt_rd_q;
      end
      tfcm_pkg::ST_RB_FIRST: pt_raddr = '0;
      tfcm_pkg::ST_RB_LAST:  pt_raddr = AW'(count_q - 1'b1);
      tfcm_pkg::ST_RB_NEXT:  pt_raddr = AW'(1);
      tfcm_pkg::ST_RB_ENTRY: begin
        pt_raddr  = AW'(seg_q + 2'd2);
        div_start = !(in_first || in_last || advance);
      end
      default: ;
    endcase
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rd_q <= pt_mem[pt_raddr];
  end

  // table memory: one write port, two read ports
  always_ff @(posedge clk_i) begin
    if (state_q == tfcm_pkg::ST_RB_WRITE) lut_mem[ent_q] <= wcol_q;
    lut_a_q <= lut_mem[idx_q];
    lut_b_q <= lut_mem[IW'(idx_q + 1'b1)];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfcm_pkg::ST_IDLE;
      count_q <= '0;
      stale_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= 1'b0;
      if (accept && !op_i) stale_q <= 1'b1;
      if (accept && op_i && count_q == '0) valid_q <= 1'b1;
      case (state_q)
        tfcm_pkg::ST_ADD_RD:  if (scan_q == count_q && full) valid_q <= 1'b1;
        tfcm_pkg::ST_ADD_CHK: if (match) valid_q <= 1'b1;
        tfcm_pkg::ST_INS_RD: begin
          if (pos_q == '0) begin
            count_q <= count_q + 1'b1;
            valid_q <= 1'b1;
          end
        end
        tfcm_pkg::ST_INS_CHK: begin
          if (!shift_up) begin
            count_q <= count_q + 1'b1;
            valid_q <= 1'b1;
          end
        end
        tfcm_pkg::ST_RB_WRITE: if (last_ent) stale_q <= 1'b0;
        tfcm_pkg::ST_MAP_LERP: valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q    <= key_in;
      col_q    <= {alpha_i[CB-1:0], blue_i[CB-1:0], green_i[CB-1:0], red_i[CB-1:0]};
      scan_q   <= '0;
      ored_q   <= '0;
      ogreen_q <= '0;
      oblue_q  <= '0;
      oalpha_q <= '0;
      ostat_q  <= (op_i && count_q == '0) ? tfcm_pkg::STATUS_EMPTY : tfcm_pkg::STATUS_DONE;
    end
    case (state_q)
      tfcm_pkg::ST_ADD_RD: begin
        pos_q <= count_q;
        if (scan_q == count_q && full) ostat_q <= tfcm_pkg::STATUS_FULL;
      end
      tfcm_pkg::ST_ADD_CHK: scan_q <= scan_q + 1'b1;
      tfcm_pkg::ST_INS_CHK: if (shift_up) pos_q <= pos_q - 1'b1;
      tfcm_pkg::ST_RB_FIRST: begin
        ent_q  <= '0;
        epos_q <= '0;
        erem_q <= '0;
        seg_q  <= '0;
      end
      tfcm_pkg::ST_RB_LAST: begin
        first_q <= pt_rd_q;
        a_q     <= pt_rd_q;
      end
      tfcm_pkg::ST_RB_NEXT: last_q <= pt_rd_q;
      tfcm_pkg::ST_RB_SEG:  b_q    <= pt_rd_q;
      tfcm_pkg::ST_RB_ENTRY: begin
        if (in_first)     wcol_q <= first_q[ColW-1:0];
        else if (in_last) wcol_q <= last_q[ColW-1:0];
        else if (advance) begin
          a_q   <= b_q;
          seg_q <= seg_q + 1'b1;
        end
      end
      tfcm_pkg::ST_RB_DIV:  if (div_done) t_q <= div_quot;
      tfcm_pkg::ST_RB_LERP: wcol_q <= {lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
      tfcm_pkg::ST_RB_WRITE: begin
        ent_q <= ent_q + 1'b1;
        if (erem_sum >= (IW+1)'(LUT_ENTRIES - 1)) begin
          epos_q <= epos_q + PW'(Q0) + 1'b1;
          erem_q <= erem_sum - (IW+1)'(LUT_ENTRIES - 1);
        end else begin
          epos_q <= epos_q + PW'(Q0);
          erem_q <= erem_sum;
        end
      end
      tfcm_pkg::ST_MAP_IDX: begin
        // the index caps only at 1.0, where the fraction is one
        if (fmul[FW-1:16] > (FW-16)'(LUT_ENTRIES - 2)) begin
          idx_q <= IW'(LUT_ENTRIES - 2);
          t_q   <= tfcm_pkg::OneQ16;
        end else begin
          idx_q <= fmul[16 +: IW];
          t_q   <= {1'b0, fmul[15:0]};
        end
      end
      tfcm_pkg::ST_MAP_LERP: begin
        ored_q   <= 16'(lane_res[0]);
        ogreen_q <= 16'(lane_res[1]);
        oblue_q  <= 16'(lane_res[2]);
        oalpha_q <= 16'(lane_res[3]);
        ostat_q  <= tfcm_pkg::STATUS_DONE;
      end
      default: ;
    endcase
  end

  assign valid_o     = valid_q;
  assign out_red_o   = ored_q;
  assign out_green_o = ogreen_q;
  assign out_blue_o  = oblue_q;
  assign out_alpha_o = oalpha_q;
  assign status_o    = ostat_q;

endmodule

// ===== hdl/tfcm_div.sv =====
// Restoring divider, one quotient bit per cycle, for table rebuild fractions.
module tfcm_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tfcm_pkg::NumW-1:0]         num_i,
  input  logic [tfcm_pkg::PosW-1:0]         den_i,
  output logic                              done_o,
  output logic [tfcm_pkg::QuoW-1:0]         quot_o
);

  localparam int unsigned CntW = $clog2(tfcm_pkg::NumW + 1);

  logic [tfcm_pkg::PosW:0]     rem_q, rem_d, rem_sh;
  logic [tfcm_pkg::NumW-1:0]   quo_q, quo_d;
  logic [tfcm_pkg::PosW-1:0]   den_q;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        run_q, run_d;
  logic                        done_q, done_d;
  logic                        fit;

  // one shift-subtract step
  always_comb begin
    rem_sh = {rem_q[tfcm_pkg::PosW-1:0], quo_q[tfcm_pkg::NumW-1]};
    fit    = rem_sh >= {1'b0, den_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = fit ? rem_sh - {1'b0, den_q} : rem_sh;
      quo_d = {quo_q[tfcm_pkg::NumW-2:0], fit};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(tfcm_pkg::NumW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quot_o = quo_q[tfcm_pkg::QuoW-1:0];

endmodule
